### rtl/frl_pkg.sv
package frl_pkg;

	localparam int MaxRanges = 1024;
	localparam int AddrW = $clog2(MaxRanges);
	localparam int CntW = AddrW + 1;
	localparam int HeldW = 11;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic CMD_GIVE = 1'b0;
	localparam logic CMD_TAKE = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [31:0] range_start;
		logic [31:0] range_end;
		logic [31:0] need_size;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] block_base;
		logic [HeldW-1:0] ranges_held;
	} out_beat_t;

	typedef enum logic [2:0] {
		DP_IDLE = 3'd0,
		DP_LOAD = 3'd1,
		DP_RD = 3'd2,
		DP_SHR = 3'd3,
		DP_SHL = 3'd4,
		DP_WR = 3'd5,
		DP_WRP = 3'd6
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [AddrW-1:0] addr;
	} dp_cmd_t;

	typedef struct packed {
		logic [31:0] rd_start;
		logic [31:0] rd_end;
		logic [CntW-1:0] count;
	} dp_stat_t;

endpackage

### rtl/frl_datapath.sv
module frl_datapath (
	input logic clk,
	input logic arst_n,
	input frl_pkg::dp_cmd_t cmd,
	input logic [31:0] wr_start,
	input logic [31:0] wr_end,
	input logic cnt_inc,
	input logic cnt_dec,
	output frl_pkg::dp_stat_t stat
);
	import frl_pkg::*;

	logic [31:0] starts_mem [MaxRanges];
	logic [31:0] ends_mem [MaxRanges];
	logic [31:0] rs_q;
	logic [31:0] re_q;
	logic [CntW-1:0] count_q;

	// read data registered; shift ops write the last read entry to addr
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_RD: begin
				rs_q <= starts_mem[cmd.addr];
				re_q <= ends_mem[cmd.addr];
			end
			DP_SHR, DP_SHL: begin
				starts_mem[cmd.addr] <= rs_q;
				ends_mem[cmd.addr] <= re_q;
			end
			DP_WR: begin
				starts_mem[cmd.addr] <= wr_start;
				ends_mem[cmd.addr] <= wr_end;
			end
			DP_WRP: begin
				ends_mem[cmd.addr] <= wr_end;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cnt_inc) begin
			count_q <= count_q + 1'b1;
		end else if (cnt_dec) begin
			count_q <= count_q - 1'b1;
		end
	end

	assign stat.rd_start = rs_q;
	assign stat.rd_end = re_q;
	assign stat.count = count_q;

endmodule

### rtl/frl_ctrl.sv
module frl_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input frl_pkg::in_beat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output frl_pkg::out_beat_t out_data,
	output frl_pkg::dp_cmd_t cmd,
	output logic [31:0] wr_start,
	output logic [31:0] wr_end,
	output logic cnt_inc,
	output logic cnt_dec,
	input frl_pkg::dp_stat_t stat
);
	import frl_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_SRD = 10'b0000000010,
		S_SCHK = 10'b0000000100,
		S_PRD = 10'b0000001000,
		S_DEC = 10'b0000010000,
		S_SHL_RD = 10'b0000100000,
		S_SHL_WR = 10'b0001000000,
		S_SHR_RD = 10'b0010000000,
		S_SHR_WR = 10'b0100000000,
		S_OUT = 10'b1000000000
	} state_t;

	state_t state_q;
	in_beat_t req_q;
	logic [CntW-1:0] k_q;
	logic [CntW-1:0] pos_q;
	logic [CntW-1:0] last_q;
	logic [31:0] next_start_q;
	logic [31:0] next_end_q;
	logic [31:0] prev_end_q;
	logic have_next_q;
	logic [1:0] status_q;
	logic [31:0] base_q;
	logic out_valid_q;
	out_beat_t out_q;

	logic [31:0] avail;
	logic [31:0] carve;
	logic jn;
	logic jp;

	assign avail = stat.rd_end - stat.rd_start;
	assign carve = stat.rd_end - req_q.need_size;
	assign jn = have_next_q && (next_start_q == req_q.range_end);
	assign jp = (pos_q != '0) && (stat.rd_end == req_q.range_start);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		cmd.op = DP_IDLE;
		cmd.addr = k_q[AddrW-1:0];
		wr_start = req_q.range_start;
		wr_end = req_q.range_end;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		unique case (state_q)
			S_SRD: begin
				if (k_q < stat.count) begin
					cmd.op = DP_RD;
				end
			end
			S_SCHK: begin
				if (req_q.cmd == CMD_TAKE && avail >= req_q.need_size) begin
					wr_start = stat.rd_start;
					wr_end = carve;
					cmd.op = (stat.rd_start == carve) ? DP_IDLE : DP_WRP;
				end
			end
			S_PRD: begin
				cmd.op = DP_RD;
				cmd.addr = pos_q[AddrW-1:0] - 1'b1;
			end
			S_DEC: begin
				if (jp && jn) begin
					cmd.op = DP_WRP;
					cmd.addr = pos_q[AddrW-1:0] - 1'b1;
					wr_end = next_end_q;
				end else if (jp) begin
					cmd.op = DP_WRP;
					cmd.addr = pos_q[AddrW-1:0] - 1'b1;
				end else if (jn) begin
					cmd.op = DP_WR;
					cmd.addr = pos_q[AddrW-1:0];
					wr_end = next_end_q;
				end else if (stat.count == CntW'(MaxRanges)) begin
					cmd.op = DP_IDLE;
				end else if (pos_q == stat.count) begin
					cmd.op = DP_WR;
					cmd.addr = pos_q[AddrW-1:0];
					cnt_inc = 1'b1;
				end
			end
			S_SHL_RD: begin
				if (k_q < last_q) begin
					cmd.op = DP_RD;
				end else begin
					cnt_dec = 1'b1;
				end
			end
			S_SHL_WR: begin
				cmd.op = DP_SHL;
				cmd.addr = k_q[AddrW-1:0] - 1'b1;
			end
			S_SHR_RD: begin
				if (k_q == pos_q) begin
					cmd.op = DP_WR;
					cmd.addr = pos_q[AddrW-1:0];
					cnt_inc = 1'b1;
				end else begin
					cmd.op = DP_RD;
					cmd.addr = k_q[AddrW-1:0] - 1'b1;
				end
			end
			S_SHR_WR: begin
				cmd.op = DP_SHR;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			k_q <= '0;
			pos_q <= '0;
			last_q <= '0;
			have_next_q <= 1'b0;
			status_q <= ST_DONE;
			base_q <= '0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						req_q <= in_data;
						k_q <= '0;
						status_q <= ST_DONE;
						base_q <= '0;
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					if (k_q < stat.count) begin
						state_q <= S_SCHK;
					end else if (req_q.cmd == CMD_TAKE) begin
						status_q <= ST_NOFIT;
						state_q <= S_OUT;
					end else begin
						pos_q <= k_q;
						have_next_q <= 1'b0;
						state_q <= (k_q != '0) ? S_PRD : S_DEC;
					end
				end
				S_SCHK: begin
					if (req_q.cmd == CMD_TAKE) begin
						if (avail >= req_q.need_size) begin
							base_q <= carve;
							if (stat.rd_start == carve) begin
								last_q <= stat.count;
								k_q <= k_q + 1'b1;
								state_q <= S_SHL_RD;
							end else begin
								state_q <= S_OUT;
							end
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= S_SRD;
						end
					end else if (stat.rd_start < req_q.range_start) begin
						k_q <= k_q + 1'b1;
						state_q <= S_SRD;
					end else begin
						pos_q <= k_q;
						have_next_q <= 1'b1;
						next_start_q <= stat.rd_start;
						next_end_q <= stat.rd_end;
						state_q <= (k_q != '0) ? S_PRD : S_DEC;
					end
				end
				S_PRD: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (jp && jn) begin
						last_q <= stat.count;
						k_q <= pos_q + 1'b1;
						state_q <= S_SHL_RD;
					end else if (jp || jn) begin
						state_q <= S_OUT;
					end else if (stat.count == CntW'(MaxRanges)) begin
						status_q <= ST_FULL;
						state_q <= S_OUT;
					end else if (pos_q == stat.count) begin
						state_q <= S_OUT;
					end else begin
						k_q <= stat.count;
						state_q <= S_SHR_RD;
					end
				end
				S_SHL_RD: begin
					state_q <= (k_q < last_q) ? S_SHL_WR : S_OUT;
				end
				S_SHL_WR: begin
					k_q <= k_q + 1'b1;
					state_q <= S_SHL_RD;
				end
				S_SHR_RD: begin
					state_q <= (k_q == pos_q) ? S_OUT : S_SHR_WR;
				end
				S_SHR_WR: begin
					k_q <= k_q - 1'b1;
					state_q <= S_SHR_RD;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q.status <= status_q;
						out_q.block_base <= base_q;
						out_q.ranges_held <= HeldW'(stat.count);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/free_range_list_allocator_top.sv
// each item takes a linear scan and, where needed, an entry-by-entry shift
// through the single-port range memory
// throughput: one item at a time; next item accepted once the result is registered
// reset: arst_n clears the range count and control; range memory is not cleared
module free_range_list_allocator_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input frl_pkg::in_beat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output frl_pkg::out_beat_t out_data
);
	import frl_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [31:0] wr_start;
	logic [31:0] wr_end;
	logic cnt_inc;
	logic cnt_dec;

	frl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cmd(cmd), .wr_start(wr_start), .wr_end(wr_end),
		.cnt_inc(cnt_inc), .cnt_dec(cnt_dec), .stat(stat)
	);

	frl_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.wr_start(wr_start), .wr_end(wr_end),
		.cnt_inc(cnt_inc), .cnt_dec(cnt_dec), .stat(stat)
	);

`ifndef SYNTHESIS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CntW'(MaxRanges)) else $error("range count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while waiting");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(cnt_inc && cnt_dec)) else $error("count inc and dec together");
`endif

endmodule
